// ===== rtl/core/oriented_box_world_aabb_macros.svh =====
// Assertion helpers, sampled on clk, off while rst_n is low
`ifndef ORIENTED_BOX_WORLD_AABB_MACROS_SVH
`define ORIENTED_BOX_WORLD_AABB_MACROS_SVH

// same-cycle implication
`define OBB_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("obb assertion failed");

// next-cycle implication
`define OBB_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("obb assertion failed");

`endif

// ===== rtl/core/obb_pkg.sv =====
package obb_pkg;

  localparam int FRAC_BITS_DEF   = 8;
  localparam int QUANT_SHIFT_DEF = 2;
  localparam int FIFO_DEPTH      = 2;

  localparam logic [63:0] GEOM_ROT_RESET = 64'h4000_0000_0000_0000;
  localparam logic signed [45:0] ONE_Q28 = 46'sd268435456;

  // operand pairs for xx,yy,zz,xy,xz,yz,wx,wy,wz (w=0,x=1,y=2,z=3)
  localparam int PA [9] = '{1, 2, 3, 1, 1, 2, 0, 0, 0};
  localparam int PB [9] = '{1, 2, 3, 2, 3, 3, 1, 2, 3};

  typedef enum logic [1:0] {
    CFG_GEOM_OFFSET = 2'd0,
    CFG_GEOM_ROT    = 2'd1,
    CFG_BOX_LO      = 2'd2,
    CFG_BOX_HI      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [62:0] body_position;
    logic [63:0] body_rotation;
  } in_req_t;

  typedef struct packed {
    logic [62:0] box_min;
    logic [62:0] box_max;
  } out_res_t;

  typedef struct packed {
    logic    valid;
    in_req_t req;
  } item_t;

  typedef logic [8:0][43:0] prod9_t;
  typedef logic [8:0][45:0] mat_t;

  function automatic logic signed [20:0] vcomp(input logic [62:0] v, input int i);
    return $signed(v[(2 - i) * 21 +: 21]);
  endfunction

  function automatic logic signed [15:0] qcomp(input logic [63:0] q, input int i);
    return $signed(q[(3 - i) * 16 +: 16]);
  endfunction

  // rotation matrix in 2^-28 units from the nine pair products
  function automatic mat_t quat_mat(input prod9_t p);
    logic signed [45:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    mat_t m;
    xx = 46'($signed(p[0])); yy = 46'($signed(p[1])); zz = 46'($signed(p[2]));
    xy = 46'($signed(p[3])); xz = 46'($signed(p[4])); yz = 46'($signed(p[5]));
    wx = 46'($signed(p[6])); wy = 46'($signed(p[7])); wz = 46'($signed(p[8]));
    m[0] = ONE_Q28 - ((yy + zz) <<< 1);
    m[1] = (xy - wz) <<< 1;
    m[2] = (xz + wy) <<< 1;
    m[3] = (xy + wz) <<< 1;
    m[4] = ONE_Q28 - ((xx + zz) <<< 1);
    m[5] = (yz - wx) <<< 1;
    m[6] = (xz - wy) <<< 1;
    m[7] = (yz + wx) <<< 1;
    m[8] = ONE_Q28 - ((xx + yy) <<< 1);
    return m;
  endfunction

  function automatic logic [20:0] sat21(input logic signed [65:0] v);
    if (v < -66'sd1048576) return 21'h100000;
    if (v > 66'sd1048575) return 21'h0FFFFF;
    return v[20:0];
  endfunction

endpackage

// ===== rtl/core/oriented_box_world_aabb.sv =====
// World axis-aligned bounds of an oriented box: one request per clock, result strobed on
// out_valid after the request has passed the request queue and then the multiplier pipeline.
// The result cannot be held off; busy only rises if the queue fills, which the free-running
// pipeline never lets happen. Write configuration only while idle.
module oriented_box_world_aabb import obb_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF,
  parameter int QUANT_SHIFT   = QUANT_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  in_req_t     in_req,
  output logic        busy,
  output logic        out_valid,
  output out_res_t    out_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [63:0] cfg_wdata
);

  logic [62:0] geom_offset_r, box_lo_r, box_hi_r;
  logic [63:0] geom_rot_r;
  item_t       item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_offset_r <= '0;
      geom_rot_r    <= GEOM_ROT_RESET;
      box_lo_r      <= '0;
      box_hi_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_GEOM_OFFSET: geom_offset_r <= cfg_wdata[62:0];
        CFG_GEOM_ROT:    geom_rot_r    <= cfg_wdata;
        CFG_BOX_LO:      box_lo_r      <= cfg_wdata[62:0];
        CFG_BOX_HI:      box_hi_r      <= cfg_wdata[62:0];
        default: ;
      endcase
    end
  end

  obb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_req (in_req),
    .busy   (busy),
    .item   (item)
  );

  obb_back #(
    .FRACTION_BITS (FRACTION_BITS),
    .QUANT_SHIFT   (QUANT_SHIFT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_item         (item),
    .geom_offset     (geom_offset_r),
    .geom_rotation   (geom_rot_r),
    .box_low_corner  (box_lo_r),
    .box_high_corner (box_hi_r),
    .out_valid       (out_valid),
    .out_res         (out_res)
  );

endmodule

// ===== rtl/core/obb_front.sv =====
`include "oriented_box_world_aabb_macros.svh"

module obb_front import obb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  in_req_t in_req,
  output logic    busy,
  output item_t   item
);

  in_req_t    mem_r [FIFO_DEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign busy = (cnt_r == 2'(FIFO_DEPTH));
  assign push = start && !busy;
  // back end never stalls, so pop whenever the queue is not empty
  assign pop  = (cnt_r != 2'd0);

  assign item.valid = pop;
  assign item.req   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  `OBB_IMPL(a_cnt_max, 1'b1, cnt_r <= 2'(FIFO_DEPTH))
  `OBB_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + 2'd1)
  `OBB_NEXT(a_rd_adv, pop, rd_ptr_r != $past(rd_ptr_r))

endmodule

// ===== rtl/core/obb_back.sv =====
`include "oriented_box_world_aabb_macros.svh"

module obb_back import obb_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF,
  parameter int QUANT_SHIFT   = QUANT_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  item_t       in_item,
  input  logic [62:0] geom_offset,
  input  logic [63:0] geom_rotation,
  input  logic [62:0] box_low_corner,
  input  logic [62:0] box_high_corner,
  output logic        out_valid,
  output out_res_t    out_res
);

  localparam int BACK = (QUANT_SHIFT <= FRACTION_BITS) ? FRACTION_BITS - QUANT_SHIFT : 0;
  localparam int K    = 29 + BACK;
  localparam logic signed [65:0] CEIL_ADD = (66'sd1 <<< K) - 66'sd1;

  logic [6:0] vld_r;

  // stage 1
  logic signed [31:0] qg_r [4][4];
  prod9_t             qp_r;
  logic signed [23:0] v_r  [3];
  logic signed [21:0] s2_1_r [3];
  logic signed [20:0] pos_1_r [3];
  // stage 2
  logic signed [19:0] pr_r [4];
  logic signed [35:0] rq_r [9];
  logic signed [23:0] v_2_r [3];
  logic signed [21:0] s2_2_r [3];
  logic signed [20:0] pos_2_r [3];
  // stage 3
  prod9_t             pp_r;
  logic signed [59:0] cv_r [9];
  logic signed [21:0] s2_3_r [3];
  logic signed [20:0] pos_3_r [3];
  // stage 4
  logic [41:0]        a_r [9];
  logic signed [65:0] c_4_r [3];
  logic signed [21:0] s2_4_r [3];
  // stage 5
  logic signed [43:0] ph_r [9];
  logic signed [43:0] pl_r [9];
  logic signed [65:0] c_5_r [3];
  // stage 6
  logic signed [65:0] s_6_r [3];
  logic signed [65:0] c_6_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_item.valid};
    end
  end
  assign out_valid = vld_r[6];

  // stage 1: pair products, centre and span
  always_ff @(posedge clk) begin
    logic signed [15:0] q [4];
    logic signed [15:0] g [4];
    logic signed [31:0] t;
    logic signed [20:0] off, lo, hi;
    for (int i = 0; i < 4; i++) begin
      q[i] = qcomp(in_item.req.body_rotation, i);
      g[i] = qcomp(geom_rotation, i);
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        qg_r[i][j] <= q[i] * g[j];
      end
    end
    for (int k = 0; k < 9; k++) begin
      t = q[PA[k]] * q[PB[k]];
      qp_r[k] <= 44'(t);
    end
    for (int i = 0; i < 3; i++) begin
      off = vcomp(geom_offset, i);
      lo  = vcomp(box_low_corner, i);
      hi  = vcomp(box_high_corner, i);
      v_r[i]     <= (24'(off) <<< 1) + 24'(lo) + 24'(hi);
      s2_1_r[i]  <= 22'(hi) - 22'(lo);
      pos_1_r[i] <= vcomp(in_item.req.body_position, i);
    end
  end

  // stage 2: combined quaternion, rounded to Q5.14; body matrix
  always_ff @(posedge clk) begin
    logic signed [33:0] p [4];
    logic signed [33:0] r;
    mat_t m;
    p[0] = 34'(qg_r[0][0]) - 34'(qg_r[1][1]) - 34'(qg_r[2][2]) - 34'(qg_r[3][3]);
    p[1] = 34'(qg_r[0][1]) + 34'(qg_r[1][0]) + 34'(qg_r[2][3]) - 34'(qg_r[3][2]);
    p[2] = 34'(qg_r[0][2]) - 34'(qg_r[1][3]) + 34'(qg_r[2][0]) + 34'(qg_r[3][1]);
    p[3] = 34'(qg_r[0][3]) + 34'(qg_r[1][2]) - 34'(qg_r[2][1]) + 34'(qg_r[3][0]);
    for (int i = 0; i < 4; i++) begin
      r = (p[i] + 34'sd8192) >>> 14;
      pr_r[i] <= r[19:0];
    end
    m = quat_mat(qp_r);
    for (int k = 0; k < 9; k++) begin
      rq_r[k] <= 36'($signed(m[k]));
    end
    v_2_r   <= v_r;
    s2_2_r  <= s2_1_r;
    pos_2_r <= pos_1_r;
  end

  // stage 3: products of the combined quaternion; rotate the centre
  always_ff @(posedge clk) begin
    logic signed [39:0] t;
    logic signed [59:0] cv;
    for (int k = 0; k < 9; k++) begin
      t = pr_r[PA[k]] * pr_r[PB[k]];
      pp_r[k] <= 44'(t);
      cv = rq_r[k] * v_2_r[k % 3];
      cv_r[k] <= cv;
    end
    s2_3_r  <= s2_2_r;
    pos_3_r <= pos_2_r;
  end

  // stage 4: absolute matrix; world centre in 2^-(F+29)
  always_ff @(posedge clk) begin
    mat_t m;
    logic signed [45:0] e, ae;
    m = quat_mat(pp_r);
    for (int k = 0; k < 9; k++) begin
      e  = $signed(m[k]);
      ae = (e < 0) ? -e : e;
      a_r[k] <= ae[41:0];
    end
    for (int i = 0; i < 3; i++) begin
      c_4_r[i] <= (66'(pos_3_r[i]) <<< 29) + 66'(cv_r[3 * i]) + 66'(cv_r[3 * i + 1])
                + 66'(cv_r[3 * i + 2]);
    end
    s2_4_r <= s2_3_r;
  end

  // stage 5: |m| * span, split into two 21-bit halves
  always_ff @(posedge clk) begin
    logic signed [21:0] ah, al;
    for (int k = 0; k < 9; k++) begin
      ah = $signed({1'b0, a_r[k][41:21]});
      al = $signed({1'b0, a_r[k][20:0]});
      ph_r[k] <= ah * s2_4_r[k % 3];
      pl_r[k] <= al * s2_4_r[k % 3];
    end
    c_5_r <= c_4_r;
  end

  // stage 6: world half-span
  always_ff @(posedge clk) begin
    logic signed [65:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc = '0;
      for (int j = 0; j < 3; j++) begin
        acc = acc + (66'(ph_r[3 * i + j]) <<< 21) + 66'(pl_r[3 * i + j]);
      end
      s_6_r[i] <= acc;
    end
    c_6_r <= c_5_r;
  end

  // stage 7: floor/ceil to the quantum, saturate
  always_ff @(posedge clk) begin
    logic signed [65:0] mn, mx;
    for (int i = 0; i < 3; i++) begin
      mn = ((c_6_r[i] - s_6_r[i]) >>> K) <<< BACK;
      mx = ((c_6_r[i] + s_6_r[i] + CEIL_ADD) >>> K) <<< BACK;
      out_res.box_min[(2 - i) * 21 +: 21] <= sat21(mn);
      out_res.box_max[(2 - i) * 21 +: 21] <= sat21(mx);
    end
  end

  `OBB_IMPL(a_latency, out_valid, $past(in_item.valid, 7))
  `OBB_NEXT(a_drain, vld_r == '0 && !in_item.valid, !out_valid)
  `OBB_IMPL(a_mid, vld_r[3], $past(vld_r[0], 3))

endmodule
